// ----- rtl/pooled_cursor_list_manager_macros.svh -----
// Assertion macros used by the checker file
`ifndef POOLED_CURSOR_LIST_MANAGER_MACROS_SVH
`define POOLED_CURSOR_LIST_MANAGER_MACROS_SVH

// Implication checked on every clock edge outside reset
`define PCLM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define PCLM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pclm_pkg.sv -----
package pclm_pkg;

    localparam int unsigned POOL_NODES_DEF = 256;
    localparam int unsigned ITEM_BITS_DEF  = 32;

    localparam int unsigned MODE_W   = 3;
    localparam int unsigned HANDLE_W = 9;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CREATED_W = 8;
    localparam int unsigned SIZE_W   = 9;

    typedef enum logic [MODE_W-1:0] {
        MODE_CREATE  = 3'd0,
        MODE_ADD     = 3'd1,
        MODE_INSERT  = 3'd2,
        MODE_APPEND  = 3'd3,
        MODE_PREPEND = 3'd4,
        MODE_CONCAT  = 3'd5
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_LIST  = 3'd1,
        ST_NULL_ITEM = 3'd2,
        ST_NO_NODE   = 3'd3,
        ST_NO_LIST   = 3'd4
    } status_t;

endpackage

// ----- rtl/pclm_ram.sv -----
module pclm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/pooled_cursor_list_manager.sv -----
// Pooled cursor list manager.
// Keeps many doubly linked lists in one shared node pool with a free list.
// Input channel: in_valid/in_stall carry mode, list_id, other_list_id and
// item_value. Output channel: out_valid/out_stall carry status,
// created_list_id and size_after, exactly one transaction per request.
// One request is handled at a time. An unused mode or a failed create
// takes the fewest steps, then a successful create or a rejected
// insertion or concat, then a concat of two lists, and an insertion the
// most. Each step is one read of a memory with a registered read port,
// followed by the link writes of the insertion or concat. The chain of
// dependent reads through the list record, the cursor node and the free
// head node sets the length. The next request is taken at the earliest in
// the cycle after its result is accepted.
// After reset the block first sweeps the forward link memory so that each
// node links to the next one; in_stall is high during the sweep. Lists and
// other tables need no clearing; every entry is written before it is read.
// When the receiver stalls, the result holds in the output register and
// the next request is not taken until the result leaves.
module pooled_cursor_list_manager
    import pclm_pkg::*;
#(
    parameter int unsigned POOL_NODES = POOL_NODES_DEF,
    parameter int unsigned ITEM_BITS  = ITEM_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [MODE_W-1:0]                   mode,
    input  logic [$clog2(POOL_NODES):0]         list_id,
    input  logic [$clog2(POOL_NODES):0]         other_list_id,
    input  logic [VALUE_W-1:0]                  item_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [STATUS_W-1:0]                 status,
    output logic [$clog2(POOL_NODES)-1:0]       created_list_id,
    output logic [$clog2(POOL_NODES):0]         size_after
);

    localparam int unsigned AW  = $clog2(POOL_NODES);
    localparam int unsigned LW  = AW + 1;
    localparam logic [LW-1:0] NIL = LW'(POOL_NODES);
    localparam int unsigned REC_W = 4 * LW;

    typedef struct packed {
        logic [LW-1:0] first;
        logic [LW-1:0] last;
        logic [LW-1:0] cursor;
        logic [LW-1:0] count;
    } rec_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD_A, S_RD_B, S_RD_N, S_RD_C, S_WR, S_FIX, S_OUT
    } state_t;

    state_t state_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [LW-1:0] a_reg, b_reg;
    logic [ITEM_BITS-1:0] item_reg;
    logic [LW-1:0] free_reg, lists_reg, clr_reg;
    rec_t ra_reg, rb_reg;
    logic [LW-1:0] n_reg, prev_reg, next_reg, fix_node_reg, fix_val_reg;
    logic fix_fwd_reg, fix_do_reg;
    logic out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [AW-1:0] created_reg;
    logic [LW-1:0] size_reg;

    // memory ports
    logic rec_we;      logic [AW-1:0] rec_wa, rec_ra; rec_t rec_wd; logic [REC_W-1:0] rec_rd;
    logic fw_we;       logic [AW-1:0] fw_wa, fw_ra;   logic [LW-1:0] fw_wd, fw_rd;
    logic bw_we;       logic [AW-1:0] bw_wa, bw_ra;   logic [LW-1:0] bw_wd, bw_rd;
    logic pl_we;       logic [AW-1:0] pl_wa;          logic [ITEM_BITS-1:0] pl_rd;

    pclm_ram #(.WIDTH(REC_W), .DEPTH(POOL_NODES)) u_rec (
        .clk(clk), .we(rec_we), .waddr(rec_wa), .wdata(rec_wd),
        .raddr(rec_ra), .rdata(rec_rd));
    pclm_ram #(.WIDTH(LW), .DEPTH(POOL_NODES)) u_fwd (
        .clk(clk), .we(fw_we), .waddr(fw_wa), .wdata(fw_wd),
        .raddr(fw_ra), .rdata(fw_rd));
    pclm_ram #(.WIDTH(LW), .DEPTH(POOL_NODES)) u_bwd (
        .clk(clk), .we(bw_we), .waddr(bw_wa), .wdata(bw_wd),
        .raddr(bw_ra), .rdata(bw_rd));
    // payload is write only here; read port follows the write address, unused
    pclm_ram #(.WIDTH(ITEM_BITS), .DEPTH(POOL_NODES)) u_pay (
        .clk(clk), .we(pl_we), .waddr(pl_wa), .wdata(item_reg),
        .raddr(pl_wa), .rdata(pl_rd));

    logic a_ok, b_ok, is_ins;
    rec_t ra_new;
    rec_t rec_q;
    logic [LW-1:0] cur;
    logic unused_ok;

    assign a_ok   = a_reg < lists_reg;
    assign b_ok   = b_reg < lists_reg;
    assign is_ins = (mode_reg == MODE_ADD) || (mode_reg == MODE_INSERT) ||
                    (mode_reg == MODE_APPEND) || (mode_reg == MODE_PREPEND);
    assign cur    = ra_reg.cursor;
    assign rec_q  = rec_t'(rec_rd);
    assign unused_ok = ^pl_rd;

    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign created_list_id = created_reg;
    assign size_after = size_reg;

    // Memory port steering
    always_comb
    begin
        rec_ra = a_reg[AW-1:0];
        fw_ra  = free_reg[AW-1:0];
        bw_ra  = cur[AW-1:0];
        rec_we = 1'b0; rec_wa = a_reg[AW-1:0]; rec_wd = ra_reg;
        fw_we  = 1'b0; fw_wa  = n_reg[AW-1:0]; fw_wd  = next_reg;
        bw_we  = 1'b0; bw_wa  = n_reg[AW-1:0]; bw_wd  = prev_reg;
        pl_we  = 1'b0; pl_wa  = n_reg[AW-1:0];
        ra_new = ra_reg;
        if (state_reg == S_IDLE)
        begin
            rec_ra = list_id[AW-1:0];
        end
        if (state_reg == S_RD_B)
        begin
            rec_ra = b_reg[AW-1:0];
        end
        if (state_reg == S_RD_N)
        begin
            fw_ra = cur[AW-1:0];
        end
        unique case (state_reg)
            S_CLEAR:
            begin
                fw_we = 1'b1;
                fw_wa = clr_reg[AW-1:0];
                fw_wd = clr_reg + LW'(1);
            end
            S_WR:
            begin
                if (mode_reg == MODE_CONCAT)
                begin
                    // relink tail of a to head of b, then clear b
                    if (ra_reg.last != NIL && rb_reg.count != '0)
                    begin
                        fw_we = 1'b1;
                        fw_wa = ra_reg.last[AW-1:0];
                        fw_wd = rb_reg.first;
                    end
                    if (ra_reg.last != NIL && rb_reg.first != NIL && rb_reg.count != '0)
                    begin
                        bw_we = 1'b1;
                        bw_wa = rb_reg.first[AW-1:0];
                        bw_wd = ra_reg.last;
                    end
                    rec_we = 1'b1;
                    rec_wa = b_reg[AW-1:0];
                    rec_wd = '{first: NIL, last: NIL, cursor: NIL, count: '0};
                end
                else
                begin
                    fw_we = 1'b1;
                    bw_we = 1'b1;
                    pl_we = 1'b1;
                end
            end
            S_FIX:
            begin
                if (mode_reg == MODE_CONCAT)
                begin
                    if (rb_reg.count != '0)
                    begin
                        if (ra_reg.last == NIL)
                        begin
                            ra_new.first = rb_reg.first;
                        end
                        ra_new.last  = rb_reg.last;
                        ra_new.count = ra_reg.count + rb_reg.count;
                    end
                end
                else
                begin
                    if (fix_do_reg)
                    begin
                        fw_we = fix_fwd_reg;
                        fw_wa = fix_node_reg[AW-1:0];
                        fw_wd = n_reg;
                    end
                    if (prev_reg == NIL)
                    begin
                        ra_new.first = n_reg;
                    end
                    if (next_reg == NIL)
                    begin
                        ra_new.last = n_reg;
                    end
                    else
                    begin
                        bw_we = 1'b1;
                        bw_wa = next_reg[AW-1:0];
                        bw_wd = n_reg;
                    end
                    ra_new.cursor = n_reg;
                    ra_new.count  = ra_reg.count + LW'(1);
                end
                rec_we = 1'b1;
                rec_wa = a_reg[AW-1:0];
                rec_wd = ra_new;
            end
            default:
            begin
            end
        endcase
    end

    // Request sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            free_reg      <= '0;
            lists_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // raise the result as the request completes, drop it once taken
            if (state_reg == S_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + LW'(1);
                    if (clr_reg == NIL - LW'(1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        mode_reg  <= mode;
                        a_reg     <= list_id;
                        b_reg     <= other_list_id;
                        item_reg  <= ITEM_BITS'(item_value);
                        state_reg <= S_RD_A;
                    end
                end
                S_RD_A:
                begin
                    if (mode_reg == MODE_CREATE && lists_reg < NIL && free_reg != NIL)
                    begin
                        // hand out the next handle and write its empty record
                        status_reg   <= ST_OK;
                        created_reg  <= lists_reg[AW-1:0];
                        size_reg     <= '0;
                        lists_reg    <= lists_reg + LW'(1);
                        ra_reg       <= '{first: NIL, last: NIL, cursor: NIL, count: '0};
                        rb_reg.count <= '0;
                        a_reg        <= lists_reg;
                        mode_reg     <= MODE_CONCAT;
                        state_reg    <= S_FIX;
                    end
                    else
                    begin
                        created_reg <= '0;
                        size_reg    <= '0;
                        if (mode_reg == MODE_CREATE && lists_reg >= NIL)
                        begin
                            status_reg <= ST_NO_LIST;
                            state_reg  <= S_OUT;
                        end
                        else if (mode_reg == MODE_CREATE)
                        begin
                            status_reg <= ST_NO_NODE;
                            state_reg  <= S_OUT;
                        end
                        else if (is_ins || mode_reg == MODE_CONCAT)
                        begin
                            status_reg <= ST_OK;
                            state_reg  <= S_RD_B;
                        end
                        else
                        begin
                            status_reg <= ST_OK;
                            state_reg  <= S_OUT;
                        end
                    end
                end
                S_RD_B:
                begin
                    ra_reg   <= rec_q;
                    size_reg <= a_ok ? rec_q.count : '0;
                    if (!a_ok)
                    begin
                        status_reg <= ST_BAD_LIST;
                        state_reg  <= S_OUT;
                    end
                    else if (is_ins)
                    begin
                        if (item_reg == '0)
                        begin
                            status_reg <= ST_NULL_ITEM;
                            state_reg  <= S_OUT;
                        end
                        else if (free_reg == NIL)
                        begin
                            status_reg <= ST_NO_NODE;
                            state_reg  <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_RD_N;
                        end
                    end
                    else if (!b_ok)
                    begin
                        status_reg <= ST_BAD_LIST;
                        state_reg  <= S_OUT;
                    end
                    else if (a_reg != b_reg)
                    begin
                        state_reg <= S_RD_C;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_RD_N:
                begin
                    // free head link is now on fw_rd; issue cursor reads
                    n_reg    <= free_reg;
                    free_reg <= fw_rd;
                    state_reg <= S_RD_C;
                end
                S_RD_C:
                begin
                    state_reg <= S_WR;
                    if (mode_reg == MODE_CONCAT)
                    begin
                        rb_reg <= rec_q;
                    end
                    else
                    begin
                        fix_fwd_reg <= 1'b1;
                        if ((mode_reg == MODE_ADD && cur != NIL))
                        begin
                            prev_reg <= cur;
                            next_reg <= fw_rd;
                            fix_node_reg <= cur;
                            fix_do_reg <= 1'b1;
                        end
                        else if (mode_reg == MODE_ADD || mode_reg == MODE_APPEND)
                        begin
                            prev_reg <= ra_reg.last;
                            next_reg <= NIL;
                            fix_node_reg <= ra_reg.last;
                            fix_do_reg <= (ra_reg.last != NIL);
                        end
                        else if (mode_reg == MODE_INSERT && cur != NIL)
                        begin
                            prev_reg <= bw_rd;
                            next_reg <= cur;
                            fix_node_reg <= bw_rd;
                            fix_do_reg <= (bw_rd != NIL);
                        end
                        else
                        begin
                            prev_reg <= NIL;
                            next_reg <= ra_reg.first;
                            fix_do_reg <= 1'b0;
                        end
                    end
                end
                S_WR:
                begin
                    state_reg <= S_FIX;
                end
                S_FIX:
                begin
                    ra_reg <= ra_new;
                    if (created_reg == '0 || status_reg != ST_OK || is_ins)
                    begin
                        size_reg <= ra_new.count;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/pclm_checker.sv -----
`include "pooled_cursor_list_manager_macros.svh"

module pclm_checker
    import pclm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [STATUS_W-1:0]  status,
    input logic [CREATED_W-1:0] created_list_id,
    input logic [SIZE_W-1:0]    size_after
);

    // a result holds while stalled
    `PCLM_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(status) && $stable(size_after), "result changed under stall")
    // one request at a time: no new transaction while a result waits
    `PCLM_ASSERT_IMP(a_one_at_a_time, out_valid, in_stall,
        "input taken while result pending")
    // accepted request cannot produce a result in the next cycle
    `PCLM_ASSERT_NEXT(a_latency, in_valid && !in_stall, !out_valid,
        "result too early")
    // create handle only on success
    `PCLM_ASSERT_IMP(a_created_ok, out_valid && created_list_id != '0, status == ST_OK,
        "handle on failure")

endmodule

bind pooled_cursor_list_manager pclm_checker u_pclm_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .created_list_id(created_list_id), .size_after(size_after));
